// File: design/horspool_substring_search_top_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the substring search block
// ---------------------------------------------------------------------------
`ifndef HORSPOOL_SUBSTRING_SEARCH_TOP_MACROS_SVH
`define HORSPOOL_SUBSTRING_SEARCH_TOP_MACROS_SVH

// Same-cycle implication, clocked on clk, off during reset.
`define HSS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk, off during reset.
`define HSS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/hss_pkg.sv
// ---------------------------------------------------------------------------
// hss_pkg
// Shared sizes, codes and controller/datapath interface types.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package hss_pkg;

  localparam int TEXT_DEPTH    = 4096;
  localparam int PATTERN_DEPTH = 256;
  localparam int ALPHABET_SIZE = 256;

  localparam int TA_W   = $clog2(TEXT_DEPTH);      // text address
  localparam int TL_W   = TA_W + 1;                // text length
  localparam int PA_W   = $clog2(PATTERN_DEPTH);   // pattern address
  localparam int PL_W   = PA_W + 1;                // pattern length / shift
  localparam int CH_W   = $clog2(ALPHABET_SIZE);   // byte value
  localparam int POS_W  = 12;
  localparam int KIND_W = 2;

  typedef enum logic [KIND_W-1:0] {
    KIND_LOAD_PAT = 2'd0,
    KIND_LOAD_TXT = 2'd1,
    KIND_SEARCH   = 2'd2,
    KIND_NONE     = 2'd3
  } hss_kind_t;

  typedef struct packed {
    logic load_pat;
    logic load_txt;
    logic start;
    logic clr_skip;
    logic i_clr;
    logic i_inc;
    logic pat_rd_i;
    logic pat_rd_last;
    logic tail_ld;
    logic skip_wr;
    logic txt_rd_tail;
    logic txt_rd_cmp;
    logic skip_rd;
    logic idx_adv;
    logic emit_hit;
    logic emit_miss;
  } hss_cmd_t;

  typedef struct packed {
    logic plen_zero;
    logic no_room;
    logic last_zero;
    logic i_nxt_last;
    logic tail_eq;
    logic byte_eq;
    logic adv_over;
    logic out_free;
  } hss_sts_t;

endpackage

`default_nettype wire

// File: design/hss_dp.sv
// ---------------------------------------------------------------------------
// hss_dp
// Buffers, shift table, scan counters and result register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hss_dp import hss_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire hss_cmd_t         cmd,
  output hss_sts_t              sts,
  input  wire logic [CH_W-1:0]  in_data_byte,
  input  wire logic             in_first_flag,
  input  wire logic [POS_W-1:0] in_start_pos,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output logic                  out_found,
  output logic [POS_W-1:0]      out_match_pos
);

  logic [CH_W-1:0] pat_mem  [PATTERN_DEPTH];
  logic [CH_W-1:0] txt_mem  [TEXT_DEPTH];
  logic [PL_W-1:0] skip_mem [ALPHABET_SIZE];

  logic [ALPHABET_SIZE-1:0] skip_vld_r;
  logic [PL_W-1:0]  plen_r;
  logic [TL_W-1:0]  tlen_r;
  logic [TL_W-1:0]  idx_r;
  logic [PA_W-1:0]  i_r;
  logic [CH_W-1:0]  tail_r;
  logic [CH_W-1:0]  pat_q;
  logic [CH_W-1:0]  txt_q;
  logic [PL_W-1:0]  skip_q;
  logic             vld_q;
  logic             out_valid_r;
  logic             out_found_r;
  logic [POS_W-1:0] out_pos_r;

  logic [PA_W-1:0] last;
  logic [PL_W-1:0] shift;
  logic [TL_W:0]   adv_sum;
  logic [TL_W-1:0] limit;
  logic [TL_W:0]   end_sum;
  logic [PA_W-1:0] pat_raddr;
  logic [TA_W-1:0] txt_raddr;

  assign last    = PA_W'(plen_r - PL_W'(1));
  assign shift   = vld_q ? skip_q : plen_r;
  assign limit   = tlen_r - TL_W'(plen_r);
  assign adv_sum = (TL_W+1)'(idx_r) + (TL_W+1)'(shift);
  assign end_sum = (TL_W+1)'(idx_r) + (TL_W+1)'(plen_r);

  assign pat_raddr = cmd.pat_rd_last ? last : i_r;
  assign txt_raddr = cmd.txt_rd_cmp ? TA_W'(idx_r + TL_W'(i_r))
                                    : TA_W'(idx_r + TL_W'(last));

  always_comb begin
    sts.plen_zero  = (plen_r == '0);
    sts.no_room    = (idx_r >= tlen_r) || (end_sum > (TL_W+1)'(tlen_r));
    sts.last_zero  = (last == '0);
    sts.i_nxt_last = (PL_W'(i_r) + PL_W'(1)) == PL_W'(last);
    sts.tail_eq    = (txt_q == tail_r);
    sts.byte_eq    = (txt_q == pat_q);
    sts.adv_over   = adv_sum > (TL_W+1)'(limit);
    sts.out_free   = !out_valid_r || !out_stall;
  end

  // Buffer and skip table writes
  always_ff @(posedge clk) begin
    if (cmd.load_pat) begin
      if (in_first_flag) begin
        pat_mem[0] <= in_data_byte;
      end else if (plen_r < PL_W'(PATTERN_DEPTH)) begin
        pat_mem[PA_W'(plen_r)] <= in_data_byte;
      end
    end
    if (cmd.load_txt) begin
      if (in_first_flag) begin
        txt_mem[0] <= in_data_byte;
      end else if (tlen_r < TL_W'(TEXT_DEPTH)) begin
        txt_mem[TA_W'(tlen_r)] <= in_data_byte;
      end
    end
    if (cmd.skip_wr) begin
      skip_mem[pat_q] <= PL_W'(last) - PL_W'(i_r);
    end
  end

  // Registered reads
  always_ff @(posedge clk) begin
    if (cmd.pat_rd_i || cmd.pat_rd_last) begin
      pat_q <= pat_mem[pat_raddr];
    end
    if (cmd.txt_rd_tail || cmd.txt_rd_cmp) begin
      txt_q <= txt_mem[txt_raddr];
    end
    if (cmd.skip_rd) begin
      skip_q <= skip_mem[txt_q];
      vld_q  <= skip_vld_r[txt_q];
    end
    if (cmd.tail_ld) begin
      tail_r <= pat_q;
    end
  end

  // Scan position, compare index and result word
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      idx_r <= TL_W'(in_start_pos);
    end else if (cmd.idx_adv) begin
      idx_r <= TL_W'(adv_sum);
    end
    if (cmd.i_clr) begin
      i_r <= '0;
    end else if (cmd.i_inc) begin
      i_r <= i_r + PA_W'(1);
    end
    out_found_r <= (cmd.emit_hit || cmd.emit_miss) ? cmd.emit_hit : out_found_r;
    if (cmd.emit_hit) begin
      out_pos_r <= POS_W'(idx_r);
    end else if (cmd.emit_miss) begin
      out_pos_r <= '0;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      plen_r      <= '0;
      tlen_r      <= '0;
      skip_vld_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.load_pat) begin
        if (in_first_flag) begin
          plen_r <= PL_W'(1);
        end else if (plen_r < PL_W'(PATTERN_DEPTH)) begin
          plen_r <= plen_r + PL_W'(1);
        end
      end
      if (cmd.load_txt) begin
        if (in_first_flag) begin
          tlen_r <= TL_W'(1);
        end else if (tlen_r < TL_W'(TEXT_DEPTH)) begin
          tlen_r <= tlen_r + TL_W'(1);
        end
      end
      if (cmd.clr_skip) begin
        skip_vld_r <= '0;
      end else if (cmd.skip_wr) begin
        skip_vld_r[pat_q] <= 1'b1;
      end
      if (cmd.emit_hit || cmd.emit_miss) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid     = out_valid_r;
  assign out_found     = out_found_r;
  assign out_match_pos = out_pos_r;

endmodule

`default_nettype wire

// File: design/hss_ctrl.sv
// ---------------------------------------------------------------------------
// hss_ctrl
// Sequencer for loads, table build, scan and compare.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hss_ctrl import hss_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [KIND_W-1:0] in_kind,
  input  wire hss_sts_t          sts,
  output hss_cmd_t               cmd
);

  typedef enum logic [12:0] {
    S_IDLE      = 13'b0000000000001,
    S_CHECK     = 13'b0000000000010,
    S_BUILD_RD  = 13'b0000000000100,
    S_BUILD_WR  = 13'b0000000001000,
    S_TAIL_RD   = 13'b0000000010000,
    S_TAIL_WR   = 13'b0000000100000,
    S_SCAN_RD   = 13'b0000001000000,
    S_SCAN_CHK  = 13'b0000010000000,
    S_SCAN_ADV  = 13'b0000100000000,
    S_CMP_RD    = 13'b0001000000000,
    S_CMP_CHK   = 13'b0010000000000,
    S_EMIT_HIT  = 13'b0100000000000,
    S_EMIT_MISS = 13'b1000000000000
  } hss_state_t;

  hss_state_t state_r, state_nxt;
  logic       accept;

  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && !in_stall;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd.load_pat = (in_kind == KIND_LOAD_PAT);
          cmd.load_txt = (in_kind == KIND_LOAD_TXT);
          if (in_kind == KIND_SEARCH) begin
            cmd.start = 1'b1;
            state_nxt = S_CHECK;
          end
        end
      end
      S_CHECK: begin
        if (sts.plen_zero) begin
          state_nxt = S_EMIT_HIT;
        end else if (sts.no_room) begin
          state_nxt = S_EMIT_MISS;
        end else begin
          cmd.clr_skip = 1'b1;
          cmd.i_clr    = 1'b1;
          state_nxt    = sts.last_zero ? S_TAIL_RD : S_BUILD_RD;
        end
      end
      S_BUILD_RD: begin
        cmd.pat_rd_i = 1'b1;
        state_nxt    = S_BUILD_WR;
      end
      S_BUILD_WR: begin
        cmd.skip_wr = 1'b1;
        cmd.i_inc   = 1'b1;
        state_nxt   = sts.i_nxt_last ? S_TAIL_RD : S_BUILD_RD;
      end
      S_TAIL_RD: begin
        cmd.pat_rd_last = 1'b1;
        state_nxt       = S_TAIL_WR;
      end
      S_TAIL_WR: begin
        cmd.tail_ld = 1'b1;
        state_nxt   = S_SCAN_RD;
      end
      S_SCAN_RD: begin
        cmd.txt_rd_tail = 1'b1;
        state_nxt       = S_SCAN_CHK;
      end
      S_SCAN_CHK: begin
        cmd.skip_rd = 1'b1;
        if (!sts.tail_eq) begin
          state_nxt = S_SCAN_ADV;
        end else if (sts.last_zero) begin
          state_nxt = S_EMIT_HIT;
        end else begin
          cmd.i_clr = 1'b1;
          state_nxt = S_CMP_RD;
        end
      end
      S_SCAN_ADV: begin
        cmd.idx_adv = 1'b1;
        state_nxt   = sts.adv_over ? S_EMIT_MISS : S_SCAN_RD;
      end
      S_CMP_RD: begin
        cmd.pat_rd_i   = 1'b1;
        cmd.txt_rd_cmp = 1'b1;
        state_nxt      = S_CMP_CHK;
      end
      S_CMP_CHK: begin
        if (!sts.byte_eq) begin
          state_nxt = S_SCAN_ADV;
        end else if (sts.i_nxt_last) begin
          state_nxt = S_EMIT_HIT;
        end else begin
          cmd.i_inc = 1'b1;
          state_nxt = S_CMP_RD;
        end
      end
      S_EMIT_HIT: begin
        if (sts.out_free) begin
          cmd.emit_hit = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      S_EMIT_MISS: begin
        if (sts.out_free) begin
          cmd.emit_miss = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

// File: design/horspool_substring_search_top.sv
// ---------------------------------------------------------------------------
// horspool_substring_search_top
// Byte-wise pattern/text loader with a Horspool substring scan.
// ---------------------------------------------------------------------------
//  Port group  Dir  Word contents
//  in_*        in   kind, data_byte, first_flag, start_pos
//  out_*       out  found, match_pos (one word per search)
//
//  Loads (pattern or text byte) and unused kinds are taken back to back.
//  Search: an empty pattern or one with no room goes straight to the result;
//  else the skip table is built, then each alignment checks its tail byte and
//  compares the rest byte by byte, with one registered buffer read per step.
//  Synchronous reset clears both lengths; buffers need no clearing pass.
//  in_stall is high during a search; out_stall holds the result word and a
//  finished search waits for the result register to drain.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "horspool_substring_search_top_macros.svh"

module horspool_substring_search_top import hss_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [KIND_W-1:0] in_kind,
  input  wire logic [CH_W-1:0]   in_data_byte,
  input  wire logic              in_first_flag,
  input  wire logic [POS_W-1:0]  in_start_pos,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic                   out_found,
  output logic [POS_W-1:0]       out_match_pos
);

  // Controller drives commands, datapath reports flags back.
  hss_cmd_t cmd;
  hss_sts_t sts;

  hss_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_kind  (in_kind),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Buffers, skip table and the result register live here.
  hss_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .in_data_byte  (in_data_byte),
    .in_first_flag (in_first_flag),
    .in_start_pos  (in_start_pos),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_found     (out_found),
    .out_match_pos (out_match_pos)
  );

  // A miss always reports position zero.
  `HSS_ASSERT_NOW(a_miss_pos_zero, out_valid && !out_found, out_match_pos == '0, "miss with nonzero position")
  // An accepted search blocks the input until it finishes.
  `HSS_ASSERT_NXT(a_search_blocks, in_valid && !in_stall && in_kind == KIND_SEARCH, in_stall, "input open during search")
  // A result is only written into a free output register.
  `HSS_ASSERT_NOW(a_emit_free, cmd.emit_hit || cmd.emit_miss, !out_valid || !out_stall, "result overwrites pending word")
  // A new result word only appears from a running search.
  `HSS_ASSERT_NOW(a_rose_from_search, $rose(out_valid), $past(in_stall), "result without a search")

endmodule

`default_nettype wire

// File: sim/horspool_substring_search_checker.sv
// ---------------------------------------------------------------------------
// horspool_substring_search_checker
// Watches both word channels of the substring search block, keeps its own
// copy of the pattern and text buffers, predicts every search result and
// compares it with the word that comes out.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module horspool_substring_search_checker import hss_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_stall,
  input  logic [KIND_W-1:0] in_kind,
  input  logic [CH_W-1:0]   in_data_byte,
  input  logic              in_first_flag,
  input  logic [POS_W-1:0]  in_start_pos,
  input  logic              out_valid,
  input  logic              out_stall,
  input  logic              out_found,
  input  logic [POS_W-1:0]  out_match_pos,
  output int                fail_count,
  output int                pending,
  output int                n_results,
  output int                n_hits
);

  typedef struct packed {
    logic             found;
    logic [POS_W-1:0] pos;
  } match_t;

  match_t          expected_matches[$];
  logic [CH_W-1:0] pat_buf [PATTERN_DEPTH];
  logic [CH_W-1:0] txt_buf [TEXT_DEPTH];
  int unsigned     pat_len;
  int unsigned     txt_len;

  // Horspool scan over the shadow buffers: first match at or after start.
  function automatic match_t find_match(input int unsigned start);
    int unsigned     shift_tbl [ALPHABET_SIZE];
    int unsigned     last, limit, idx, i;
    logic [CH_W-1:0] tail, c;
    bit              same;
    match_t          m;
    m = '0;
    if (pat_len == 0) begin
      m.found = 1'b1;
      m.pos   = POS_W'(start);
      return m;
    end
    if (start >= txt_len || start + pat_len > txt_len) return m;
    last = pat_len - 1;
    for (i = 0; i < ALPHABET_SIZE; i++) shift_tbl[i] = pat_len;
    for (i = 0; i < last; i++) shift_tbl[pat_buf[i]] = last - i;
    tail  = pat_buf[last];
    limit = txt_len - pat_len;
    idx   = start;
    while (idx <= limit) begin
      c = txt_buf[idx + last];
      if (c == tail) begin
        same = 1'b1;
        for (i = 0; i < last && same; i++)
          if (txt_buf[idx + i] != pat_buf[i]) same = 1'b0;
        if (same) begin
          m.found = 1'b1;
          m.pos   = POS_W'(idx);
          return m;
        end
      end
      idx += shift_tbl[c];
    end
    return m;
  endfunction

  always @(posedge clk) begin : watch
    match_t want;
    if (!rst_n) begin
      pat_len = 0;
      txt_len = 0;
      expected_matches.delete();
    end else begin
      // result side first: a word accepted now cannot belong to this edge's input
      if (out_valid && !out_stall) begin
        n_results++;
        if (out_found) n_hits++;
        if (expected_matches.size() == 0) begin
          $display("%0t ns: unexpected result word, found=%0b match_pos=%0d",
                   $time, out_found, out_match_pos);
          fail_count++;
        end else begin
          want = expected_matches.pop_front();
          if (out_found !== want.found) begin
            $display("%0t ns: found mismatch, expected %0b, actual %0b",
                     $time, want.found, out_found);
            fail_count++;
          end
          if (out_match_pos !== want.pos) begin
            $display("%0t ns: match_pos mismatch, expected %0d, actual %0d",
                     $time, want.pos, out_match_pos);
            fail_count++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        case (hss_kind_t'(in_kind))
          KIND_LOAD_PAT: begin
            if (in_first_flag) pat_len = 0;
            if (pat_len < PATTERN_DEPTH) begin
              pat_buf[pat_len] = in_data_byte;
              pat_len++;
            end
          end
          KIND_LOAD_TXT: begin
            if (in_first_flag) txt_len = 0;
            if (txt_len < TEXT_DEPTH) begin
              txt_buf[txt_len] = in_data_byte;
              txt_len++;
            end
          end
          KIND_SEARCH: expected_matches.push_back(find_match(in_start_pos));
          default: ;
        endcase
      end
    end
    pending = expected_matches.size();
  end

endmodule

// File: sim/horspool_substring_search_top_test.sv
// ---------------------------------------------------------------------------
// horspool_substring_search_top_test
// Stimulus and verdict for the substring search block. A short directed
// sequence hits the corner cases, the pattern buffer is then filled to
// depth, and the bulk of the run is random pattern/text/search scenarios
// with bursty input, random output stalls and one long output hold-off.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module horspool_substring_search_top_test;
  import hss_pkg::*;

  // random part size, in input words that do something
  localparam int RANDOM_WORDS = 600;
  // length of the long output hold-off, in cycles
  localparam int HOLD_CYCLES  = 2000;

  logic              clk;
  logic              rst_n         = 1'b0;
  logic              in_valid      = 1'b0;
  logic              in_stall;
  logic [KIND_W-1:0] in_kind       = KIND_NONE;
  logic [CH_W-1:0]   in_data_byte  = '0;
  logic              in_first_flag = 1'b0;
  logic [POS_W-1:0]  in_start_pos  = '0;
  logic              out_valid;
  logic              out_stall     = 1'b0;
  logic              out_found;
  logic [POS_W-1:0]  out_match_pos;

  int fail_count, pending, n_results, n_hits;

  // sender / receiver shaping knobs, changed between scenarios
  int items_sent  = 0;
  int burst_left  = 0;
  bit gaps_on     = 1'b0;
  int stall_mode  = 0;
  bit hold_armed  = 1'b0;
  bit hold_done   = 1'b0;

  // what has been loaded so far, only used to build useful stimulus
  logic [CH_W-1:0] txt_img [TEXT_DEPTH];
  logic [CH_W-1:0] pat_img [PATTERN_DEPTH];
  int t_len = 0;
  int p_len = 0;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  horspool_substring_search_top dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_kind       (in_kind),
    .in_data_byte  (in_data_byte),
    .in_first_flag (in_first_flag),
    .in_start_pos  (in_start_pos),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_found     (out_found),
    .out_match_pos (out_match_pos)
  );

  horspool_substring_search_checker chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_kind       (in_kind),
    .in_data_byte  (in_data_byte),
    .in_first_flag (in_first_flag),
    .in_start_pos  (in_start_pos),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_found     (out_found),
    .out_match_pos (out_match_pos),
    .fail_count    (fail_count),
    .pending       (pending),
    .n_results     (n_results),
    .n_hits        (n_hits)
  );

  // Offer one word and return at the edge where it is taken.
  // Always entered at a rising edge; in_valid gets a single NBA per step:
  // either lowered for a gap, or raised (kept high) for the next word.
  task automatic send_word(input hss_kind_t kind, input logic [CH_W-1:0] b,
                           input logic first, input logic [POS_W-1:0] pos);
    int gap;
    if (gaps_on && burst_left == 0) begin
      gap = $urandom_range(1, 8);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = $urandom_range(1, 12);
    end
    in_valid      <= 1'b1;
    in_kind       <= kind;
    in_data_byte  <= b;
    in_first_flag <= first;
    in_start_pos  <= pos;
    // in_stall is read before the edge's updates land
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (burst_left > 0) burst_left--;
    if (kind != KIND_NONE) items_sent++;
  endtask

  // Loads keep the local image in step; unused fields get random values.
  task automatic load_pat(input logic [CH_W-1:0] b, input logic first);
    send_word(KIND_LOAD_PAT, b, first, POS_W'($urandom));
    if (first) p_len = 0;
    if (p_len < PATTERN_DEPTH) begin
      pat_img[p_len] = b;
      p_len++;
    end
  endtask

  task automatic load_txt(input logic [CH_W-1:0] b, input logic first);
    send_word(KIND_LOAD_TXT, b, first, POS_W'($urandom));
    if (first) t_len = 0;
    if (t_len < TEXT_DEPTH) begin
      txt_img[t_len] = b;
      t_len++;
    end
  endtask

  task automatic search_at(input int unsigned pos);
    send_word(KIND_SEARCH, CH_W'($urandom), 1'($urandom), POS_W'(pos));
  endtask

  // Narrow mode draws from two symbols so matches and near misses are common.
  function automatic logic [CH_W-1:0] pick_symbol(input bit narrow,
                                                  input logic [CH_W-1:0] a,
                                                  input logic [CH_W-1:0] b);
    if (narrow) return $urandom_range(0, 1) ? a : b;
    return CH_W'($urandom);
  endfunction

  // One random scenario. Most are well formed: fresh pattern, fresh text
  // seeded with copies of it, then a few searches. The rest append to a
  // buffer, swap only the pattern, or throw in noise words of any kind.
  task automatic random_scenario(input bit fresh);
    int              r, plen, tlen, n, i, k, at;
    bit              narrow;
    logic [CH_W-1:0] sym_a, sym_b;
    logic [CH_W-1:0] txt_new [64];
    narrow     = $urandom_range(0, 2) != 0;
    sym_a      = CH_W'($urandom);
    sym_b      = CH_W'($urandom);
    stall_mode = $urandom_range(0, 3);
    gaps_on    = $urandom_range(0, 2) != 0;
    r          = fresh ? 0 : $urandom_range(0, 9);

    if (r <= 6) begin
      // mostly short patterns, now and then a longer one
      plen = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 24) : $urandom_range(1, 8);
      for (i = 0; i < plen; i++) load_pat(pick_symbol(narrow, sym_a, sym_b), i == 0);
    end
    if (r <= 5) begin
      tlen = $urandom_range(1, 64);
      for (i = 0; i < tlen; i++) txt_new[i] = pick_symbol(narrow, sym_a, sym_b);
      n = $urandom_range(0, 2);
      for (k = 0; k < n; k++)
        if (p_len <= tlen) begin
          at = $urandom_range(0, tlen - p_len);
          for (i = 0; i < p_len; i++) txt_new[at + i] = pat_img[i];
        end
      for (i = 0; i < tlen; i++) load_txt(txt_new[i], i == 0);
    end else if (r == 7) begin
      n = $urandom_range(1, 8);
      for (i = 0; i < n; i++) load_txt(pick_symbol(narrow, sym_a, sym_b), 1'b0);
    end else if (r == 8) begin
      n = $urandom_range(1, 3);
      for (i = 0; i < n; i++) load_pat(pick_symbol(narrow, sym_a, sym_b), 1'b0);
    end

    if (r == 9) begin
      // noise: any kind, any flags, any start
      n = $urandom_range(1, 6);
      for (i = 0; i < n; i++)
        case ($urandom_range(0, 3))
          0: load_pat(CH_W'($urandom), 1'($urandom));
          1: load_txt(CH_W'($urandom), 1'($urandom));
          2: search_at($urandom_range(0, 4095));
          default: send_word(KIND_NONE, CH_W'($urandom), 1'($urandom), POS_W'($urandom));
        endcase
    end else begin
      n = $urandom_range(1, 4);
      for (i = 0; i < n; i++) begin
        k = $urandom_range(0, 9);
        if (k < 8)
          search_at($urandom_range(0, t_len + 1));
        else if (k == 8)
          search_at($urandom_range(0, 4095));
        else
          search_at((t_len >= p_len) ? t_len - p_len : 0);  // exact fit at the end
      end
    end
  endtask

  // Receiver: stall pattern by mode, plus one long hold-off when armed.
  initial begin : receiver
    int hold, cyc;
    cyc = 0;
    forever begin
      @(posedge clk);
      cyc++;
      if (hold_armed && !hold_done) begin
        // block fills: result register held, next search stalls the input
        out_stall <= 1'b1;
        for (hold = 0; hold < HOLD_CYCLES; hold++) @(posedge clk);
        hold_done = 1'b1;
      end
      case (stall_mode)
        0:       out_stall <= 1'b0;
        1:       out_stall <= ($urandom_range(0, 3) == 0);
        2:       out_stall <= ($urandom_range(0, 9) < 7);
        default: out_stall <= ((cyc % 5) < 3);
      endcase
    end
  end

  initial begin : stimulus
    int i, rand_base;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // ---- directed corner cases ----
    stall_mode = 1;
    gaps_on    = 1'b0;
    // empty pattern right after reset: found at start, text ignored
    search_at(0);
    search_at(4095);
    // unused kind: no result, no state change
    send_word(KIND_NONE, 8'hFF, 1'b1, 12'hFFF);
    // pattern FF 00, text 00 FF 00 FF 00: hits at 1 and 3
    load_pat(8'hFF, 1'b1);
    load_pat(8'h00, 1'b0);
    load_txt(8'h00, 1'b1);
    load_txt(8'hFF, 1'b0);
    load_txt(8'h00, 1'b0);
    load_txt(8'hFF, 1'b0);
    load_txt(8'h00, 1'b0);
    search_at(0);
    search_at(2);
    search_at(3);      // pattern ends on the last text byte
    search_at(4);      // start plus pattern runs past the text
    search_at(4095);   // start beyond the text
    // single byte pattern
    load_pat(8'h00, 1'b1);
    search_at(0);
    search_at(1);

    // ---- pattern buffer to full depth ----
    stall_mode = 2;
    gaps_on    = 1'b1;
    for (i = 0; i < PATTERN_DEPTH + 2; i++)
      load_pat(CH_W'($urandom), i == 0);   // last two are dropped: buffer full
    // full pattern against a text with one copy planted at 40
    for (i = 0; i < 320; i++)
      load_txt((i >= 40 && i < 40 + PATTERN_DEPTH) ? pat_img[i-40] : CH_W'($urandom),
               i == 0);
    search_at(0);
    search_at(41);
    search_at(320 - PATTERN_DEPTH);
    search_at(4095);
    // pattern taken from the tail of the text
    load_pat(txt_img[317], 1'b1);
    load_pat(txt_img[318], 1'b0);
    load_pat(txt_img[319], 1'b0);
    search_at(200);
    search_at(317);
    search_at(318);

    // ---- random scenarios ----
    rand_base = items_sent;
    random_scenario(1'b1);
    while (items_sent < rand_base + RANDOM_WORDS) begin
      random_scenario(1'b0);
      if (!hold_armed && items_sent > rand_base + 300) hold_armed = 1'b1;
    end

    // ---- drain and verdict ----
    in_valid  <= 1'b0;
    stall_mode = 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (64) @(posedge clk);
    $display("Run: %0d input words, %0d result words (%0d found), empty pattern,",
             items_sent, n_results, n_hits);
    $display("  full pattern buffer, unused kind, no-room starts and a long output hold-off.");
    if (fail_count == 0 && pending == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin : watchdog
    #(100_000_000);
    $display("Timeout: stimulus or results did not complete");
    $display("Some tests failed");
    $finish;
  end

endmodule
